/* hw/rtl/rmj_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared defaults for the radar measurement Jacobian block.
// ----------------------------------------------------------------------------
package rmj_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

endpackage
`default_nettype wire

/* hw/rtl/rmj_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_if
// Valid/ready channels: filter state in, Jacobian entries out.
// ----------------------------------------------------------------------------
interface rmj_in_if #(
  parameter int unsigned WORD_BITS = rmj_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] pos_x;
  logic [WORD_BITS-1:0] pos_y;
  logic [WORD_BITS-1:0] vel_x;
  logic [WORD_BITS-1:0] vel_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_out_if #(
  parameter int unsigned WORD_BITS = rmj_pkg::WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] range_by_px;
  logic [WORD_BITS-1:0] range_by_py;
  logic [WORD_BITS-1:0] bearing_by_px;
  logic [WORD_BITS-1:0] bearing_by_py;
  logic [WORD_BITS-1:0] rate_by_px;
  logic [WORD_BITS-1:0] rate_by_py;
  logic                 saturated;

  modport source (output valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
                  rate_by_px, rate_by_py, saturated, input ready);
  modport sink   (input valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
                  rate_by_px, rate_by_py, saturated, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rmj_dly.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_dly
// Enabled shift line that carries side data alongside the arithmetic stages.
// ----------------------------------------------------------------------------
module rmj_dly #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule
`default_nettype wire

/* hw/rtl/rmj_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module rmj_div #(
  parameter int unsigned NW = 96,
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 33
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quot_o,
  output logic               ovf_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_w;
  logic [DW-1:0] rem0;
  logic          ovf0;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lq_q  [QW];
  logic [DW-1:0] den_q [QW];
  logic          ovf_q [QW];

  assign hi_w = CW'(num_i[NW-1:QW]);
  assign rem0 = hi_w[DW-1:0];
  assign ovf0 = hi_w >= CW'(den_i);

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lq_in;
    logic          ovf_in;
    logic [DW:0]   r2;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = rem0;
      assign den_in = den_i;
      assign lq_in  = num_i[QW-1:0];
      assign ovf_in = ovf0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign lq_in  = lq_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    assign r2   = {rem_in, lq_in[QW-1]};
    assign ge   = r2 >= {1'b0, den_in};
    assign diff = r2 - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        lq_q[k]  <= {lq_in[QW-2:0], ge};
        den_q[k] <= den_in;
        ovf_q[k] <= ovf_in;
      end
    end
  end

  assign quot_o = lq_q[QW-1];
  assign ovf_o  = ovf_q[QW-1];

endmodule
`default_nettype wire

/* hw/rtl/rmj_sqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmj_sqrt #(
  parameter int unsigned K = 17
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [2*K-1:0] op_i,
  output logic      [K-1:0]   root_o
);

  logic [K+1:0]   rem_q  [K];
  logic [K-1:0]   root_q [K];
  logic [2*K-1:0] op_q   [K];

  for (genvar j = 0; j < K; j++) begin : g_st
    logic [K+1:0]   rem_in;
    logic [K-1:0]   root_in;
    logic [2*K-1:0] op_in;
    logic [K+3:0]   r2;
    logic [K+3:0]   trial;
    logic [K+3:0]   diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = op_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign op_in   = op_q[j-1];
    end

    assign r2    = {rem_in, op_in[2*K-1:2*K-2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = r2 >= trial;
    assign diff  = r2 - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[K+1:0] : r2[K+1:0];
        root_q[j] <= {root_in[K-2:0], ge};
        op_q[j]   <= {op_in[2*K-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[K-1];

endmodule
`default_nettype wire

/* hw/rtl/radar_measurement_jacobian_top.sv */
`default_nettype none
// Throughput: one state per cycle while the output is not stalled; the bit-per-stage
// dividers and square roots set the depth.
// A stalled output freezes the whole pipeline; ready is high whenever the output is free.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_top
// Jacobian of the polar radar measurement for one constant-velocity state.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_top #(
  parameter int unsigned FRAC_BITS = rmj_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = rmj_pkg::WORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rmj_in_if.sink     in_i,
  rmj_out_if.source  out_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned K  = F + 1;
  localparam int unsigned QA = 2 * F + 1;
  localparam int unsigned QR = W + 1;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned NA = 2 * W + 2 * F;
  localparam int unsigned NR = K + 2 * W;
  localparam int unsigned LT = 6 + QA + K + QR;
  localparam int unsigned CW = (QA > QR) ? QA : QR;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    return x[W-1] ? (W'(0) - x) : x;
  endfunction

  function automatic logic [W:0] clip(input logic [CW-1:0] mag, input logic neg,
                                      input logic ovf);
    logic [CW-1:0] lim;
    logic [W-1:0]  m;
    logic          sat;
    lim = (CW'(1) << (W - 1)) - CW'(neg ? 1'b0 : 1'b1);
    sat = ovf || (mag > lim);
    m   = sat ? lim[W-1:0] : mag[W-1:0];
    return {sat, neg ? (W'(0) - m) : m};
  endfunction

  logic          en;
  logic [LT-1:0] v_q;

  assign en         = !v_q[LT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LT-2:0], in_i.valid};
    end
  end

  // input stage
  logic         origin;
  logic [W-1:0] pxm_q, pym_q, vxm_q, vym_q;
  logic         pxn_q, pyn_q, vxn_q, vyn_q;

  assign origin = (in_i.pos_x == '0) && (in_i.pos_y == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxm_q <= origin ? W'(1) : mag_of(in_i.pos_x);
      pym_q <= origin ? W'(1) : mag_of(in_i.pos_y);
      pxn_q <= in_i.pos_x[W-1];
      pyn_q <= in_i.pos_y[W-1];
      vxm_q <= mag_of(in_i.vel_x);
      vym_q <= mag_of(in_i.vel_y);
      vxn_q <= in_i.vel_x[W-1];
      vyn_q <= in_i.vel_y[W-1];
    end
  end

  // products
  logic [DW-1:0] px2_q, py2_q, p1m_q, p2m_q;
  logic          p1n_q, p2n_q, pxn_a_q, pyn_a_q;
  logic [W-1:0]  pxm_a_q, pym_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px2_q   <= DW'(pxm_q) * DW'(pxm_q);
      py2_q   <= DW'(pym_q) * DW'(pym_q);
      p1m_q   <= DW'(vxm_q) * DW'(pym_q);
      p2m_q   <= DW'(vym_q) * DW'(pxm_q);
      p1n_q   <= vxn_q ^ pyn_q;
      p2n_q   <= vyn_q ^ pxn_q;
      pxm_a_q <= pxm_q;
      pym_a_q <= pym_q;
      pxn_a_q <= pxn_q;
      pyn_a_q <= pyn_q;
    end
  end

  // sums and numerators
  logic [DW+1:0] e1, e2, t1, t2, diff, cabs;
  logic [DW-1:0] c1_q, crossm_q;
  logic          crossn_q, pxn_b_q, pyn_b_q;
  logic [NA-1:0] nrx_q, nry_q, nbx_q, nby_q;

  assign e1   = {2'b00, p1m_q};
  assign e2   = {2'b00, p2m_q};
  assign t1   = p1n_q ? ((DW + 2)'(0) - e1) : e1;
  assign t2   = p2n_q ? ((DW + 2)'(0) - e2) : e2;
  assign diff = t1 - t2;
  assign cabs = diff[DW+1] ? ((DW + 2)'(0) - diff) : diff;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q     <= px2_q + py2_q;
      crossm_q <= cabs[DW-1:0];
      crossn_q <= diff[DW+1];
      nrx_q    <= {px2_q, {(2 * F){1'b0}}};
      nry_q    <= {py2_q, {(2 * F){1'b0}}};
      nbx_q    <= NA'(pym_a_q) << (2 * F);
      nby_q    <= NA'(pxm_a_q) << (2 * F);
      pxn_b_q  <= pxn_a_q;
      pyn_b_q  <= pyn_a_q;
    end
  end

  // first divisions by c1
  logic [QA-1:0] q_rx, q_ry, q_bx, q_by;

  rmj_div #(.NW(NA), .DW(DW), .QW(QA)) u_div_rx (
    .clk_i(clk_i), .en_i(en), .num_i(nrx_q), .den_i(c1_q), .quot_o(q_rx), .ovf_o()
  );
  rmj_div #(.NW(NA), .DW(DW), .QW(QA)) u_div_ry (
    .clk_i(clk_i), .en_i(en), .num_i(nry_q), .den_i(c1_q), .quot_o(q_ry), .ovf_o()
  );
  rmj_div #(.NW(NA), .DW(DW), .QW(QA)) u_div_bx (
    .clk_i(clk_i), .en_i(en), .num_i(nbx_q), .den_i(c1_q), .quot_o(q_bx), .ovf_o()
  );
  rmj_div #(.NW(NA), .DW(DW), .QW(QA)) u_div_by (
    .clk_i(clk_i), .en_i(en), .num_i(nby_q), .den_i(c1_q), .quot_o(q_by), .ovf_o()
  );

  // range entries
  logic [K-1:0] rx, ry;

  rmj_sqrt #(.K(K)) u_sqrt_rx (
    .clk_i(clk_i), .en_i(en), .op_i({1'b0, q_rx}), .root_o(rx)
  );
  rmj_sqrt #(.K(K)) u_sqrt_ry (
    .clk_i(clk_i), .en_i(en), .op_i({1'b0, q_ry}), .root_o(ry)
  );

  // side data
  logic [DW-1:0]   c1_d, crossm_d;
  logic [2*QA-1:0] bq_d;
  logic [2:0]      sg_d;
  logic [2*K-1:0]  r_d;

  rmj_dly #(.WIDTH(2 * DW), .DEPTH(QA + K)) u_dly_c1 (
    .clk_i(clk_i), .en_i(en), .d_i({c1_q, crossm_q}), .q_o({c1_d, crossm_d})
  );
  rmj_dly #(.WIDTH(2 * QA), .DEPTH(K + 2 + QR)) u_dly_bq (
    .clk_i(clk_i), .en_i(en), .d_i({q_bx, q_by}), .q_o(bq_d)
  );
  rmj_dly #(.WIDTH(3), .DEPTH(QA + K + 2 + QR)) u_dly_sg (
    .clk_i(clk_i), .en_i(en), .d_i({pxn_b_q, pyn_b_q, crossn_q}), .q_o(sg_d)
  );
  rmj_dly #(.WIDTH(2 * K), .DEPTH(2 + QR)) u_dly_r (
    .clk_i(clk_i), .en_i(en), .d_i({rx, ry}), .q_o(r_d)
  );

  // rate numerators, split in two partial products
  logic [K+W-1:0] plo_x_q, phi_x_q, plo_y_q, phi_y_q;
  logic [DW-1:0]  c1_m1_q, c1_m2_q;
  logic [NR-1:0]  prod_x_q, prod_y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_x_q  <= (K + W)'(ry) * (K + W)'(crossm_d[W-1:0]);
      phi_x_q  <= (K + W)'(ry) * (K + W)'(crossm_d[DW-1:W]);
      plo_y_q  <= (K + W)'(rx) * (K + W)'(crossm_d[W-1:0]);
      phi_y_q  <= (K + W)'(rx) * (K + W)'(crossm_d[DW-1:W]);
      c1_m1_q  <= c1_d;
      prod_x_q <= NR'(plo_x_q) + (NR'(phi_x_q) << W);
      prod_y_q <= NR'(plo_y_q) + (NR'(phi_y_q) << W);
      c1_m2_q  <= c1_m1_q;
    end
  end

  logic [QR-1:0] q_tx, q_ty;
  logic          ovf_tx, ovf_ty;

  rmj_div #(.NW(NR), .DW(DW), .QW(QR)) u_div_tx (
    .clk_i(clk_i), .en_i(en), .num_i(prod_x_q), .den_i(c1_m2_q), .quot_o(q_tx),
    .ovf_o(ovf_tx)
  );
  rmj_div #(.NW(NR), .DW(DW), .QW(QR)) u_div_ty (
    .clk_i(clk_i), .en_i(en), .num_i(prod_y_q), .den_i(c1_m2_q), .quot_o(q_ty),
    .ovf_o(ovf_ty)
  );

  // clip and register the result
  logic         sxn, syn, scn;
  logic [W:0]   o_rx, o_ry, o_bx, o_by, o_tx, o_ty;
  logic [W-1:0] rx_q, ry_q, bx_q, by_q, tx_q, ty_q;
  logic         sat_q;

  assign {sxn, syn, scn} = sg_d;
  assign o_rx = clip(CW'(r_d[2*K-1:K]), sxn, 1'b0);
  assign o_ry = clip(CW'(r_d[K-1:0]), syn, 1'b0);
  assign o_bx = clip(CW'(bq_d[2*QA-1:QA]), !syn, 1'b0);
  assign o_by = clip(CW'(bq_d[QA-1:0]), sxn, 1'b0);
  assign o_tx = clip(CW'(q_tx), syn ^ scn, ovf_tx);
  assign o_ty = clip(CW'(q_ty), sxn ^ !scn, ovf_ty);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= o_rx[W-1:0];
      ry_q  <= o_ry[W-1:0];
      bx_q  <= o_bx[W-1:0];
      by_q  <= o_by[W-1:0];
      tx_q  <= o_tx[W-1:0];
      ty_q  <= o_ty[W-1:0];
      sat_q <= o_rx[W] | o_ry[W] | o_bx[W] | o_by[W] | o_tx[W] | o_ty[W];
    end
  end

  assign out_o.valid         = v_q[LT-1];
  assign out_o.range_by_px   = rx_q;
  assign out_o.range_by_py   = ry_q;
  assign out_o.bearing_by_px = bx_q;
  assign out_o.bearing_by_py = by_q;
  assign out_o.rate_by_px    = tx_q;
  assign out_o.rate_by_py    = ty_q;
  assign out_o.saturated     = sat_q;

endmodule
`default_nettype wire

/* hw/rtl/rmj_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmj_checker
// Port-level checks for the radar measurement Jacobian block.
// ----------------------------------------------------------------------------
module rmj_checker #(
  parameter int unsigned FRAC_BITS = rmj_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = rmj_pkg::WORD_BITS_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_ready_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [WORD_BITS-1:0] range_by_px_i,
  input wire logic [WORD_BITS-1:0] range_by_py_i,
  input wire logic [WORD_BITS-1:0] rate_by_px_i,
  input wire logic                 saturated_i
);

  localparam logic signed [WORD_BITS:0] RMAX = (WORD_BITS + 1)'(1) << FRAC_BITS;

  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($signed({range_by_px_i[WORD_BITS-1], range_by_px_i}) <= RMAX) &&
                    ($signed({range_by_px_i[WORD_BITS-1], range_by_px_i}) >= -RMAX) &&
                    ($signed({range_by_py_i[WORD_BITS-1], range_by_py_i}) <= RMAX) &&
                    ($signed({range_by_py_i[WORD_BITS-1], range_by_py_i}) >= -RMAX))
    else $error("range entry beyond unit magnitude");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(range_by_px_i) &&
                                    $stable(rate_by_px_i) && $stable(saturated_i))
    else $error("stalled transfer changed");

endmodule

bind radar_measurement_jacobian_top rmj_checker #(
  .FRAC_BITS(FRAC_BITS),
  .WORD_BITS(WORD_BITS)
) u_rmj_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .range_by_px_i (out_o.range_by_px),
  .range_by_py_i (out_o.range_by_py),
  .rate_by_px_i  (out_o.rate_by_px),
  .saturated_i   (out_o.saturated)
);
`default_nettype wire
